@@ rtl/core/slto_pkg.sv @@
// Shared constants, side-band types and helper functions of the junction observables pipeline.
package slto_pkg;

  localparam int COND_FRAC  = 28;
  localparam int ANGLE_FRAC = 30;
  // Depth of every parallel branch: CORDIC, coupling divider, transmissions.
  localparam int BR_LAT     = 32;
  // Quotient bits of the static conductance divider.
  localparam int SD_STEPS   = 32;
  // Quotient bits of a transmission (one integer bit, COND_FRAC fraction bits).
  localparam int TR_STEPS   = COND_FRAC + 1;

  localparam logic [31:0] SAT_MAX = 32'h7fff_ffff;
  localparam logic [31:0] SAT_MIN = 32'h8000_0000;
  localparam logic [31:0] TR_ONE  = 32'h1000_0000;

  localparam logic [31:0] ATAN_TAB [10] = '{
    32'd843314857, 32'd497837829, 32'd263043837, 32'd133525159, 32'd67021687,
    32'd33543516,  32'd16775851,  32'd8388437,   32'd4194283,   32'd2097149
  };

  typedef struct packed {
    logic signed [31:0] v;
    logic signed [32:0] wl;
    logic signed [32:0] wr;
    logic               fs;
    logic               fv;
  } br_side_t;

  typedef struct packed {
    logic [31:0]          cur;
    logic [31:0]          diff;
    logic [TR_STEPS-1:0]  td;
    logic                 neg;
    logic                 fs;
    logic                 fv;
  } sd_side_t;

  // Stage angle in Q.30 radians.
  function automatic logic [31:0] cordic_angle(input int unsigned i);
    logic [31:0] ang;
    if (i < 10) begin
      ang = ATAN_TAB[i[3:0]];
    end else if (i <= ANGLE_FRAC) begin
      ang = 32'(1) << (ANGLE_FRAC - i);
    end else begin
      ang = '0;
    end
    return ang;
  endfunction

  function automatic logic [31:0] sat_to32(input logic signed [63:0] val);
    logic [31:0] res;
    if (val > 64'sh0000_0000_7fff_ffff) begin
      res = SAT_MAX;
    end else if (val < -64'sh0000_0000_8000_0000) begin
      res = SAT_MIN;
    end else begin
      res = val[31:0];
    end
    return res;
  endfunction

endpackage

@@ rtl/core/slto_cordic.sv @@
// Pipelined vectoring CORDIC: angle of (x, y), one stage per register.
module slto_cordic #(
  parameter int Y_W    = 43,
  parameter int STAGES = 24
) (
  input  logic                  clk,
  input  logic                  en,
  input  logic signed [Y_W-1:0] y_in,
  input  logic [31:0]           x_in,
  output logic signed [31:0]    z_out
);
  import slto_pkg::*;

  localparam int CX_W = Y_W + 3;

  logic signed [CX_W-1:0] x_r [BR_LAT];
  logic signed [CX_W-1:0] y_r [BR_LAT];
  logic signed [31:0]     z_r [BR_LAT];

  for (genvar i = 0; i < BR_LAT; i++) begin : g_stage
    logic signed [CX_W-1:0] x_prev, y_prev, x_nxt, y_nxt;
    logic signed [31:0]     z_prev, z_nxt;

    if (i == 0) begin : g_first
      assign x_prev = CX_W'(x_in);
      assign y_prev = CX_W'(y_in);
      assign z_prev = '0;
    end else begin : g_next
      assign x_prev = x_r[i-1];
      assign y_prev = y_r[i-1];
      assign z_prev = z_r[i-1];
    end

    if (i < STAGES) begin : g_rot
      logic signed [CX_W-1:0] xs, ys;
      assign xs = x_prev >>> i;
      assign ys = y_prev >>> i;
      always_comb begin
        // rotate toward the x axis
        if (y_prev[CX_W-1]) begin
          x_nxt = x_prev - ys;
          y_nxt = y_prev + xs;
          z_nxt = z_prev - $signed(cordic_angle(i));
        end else begin
          x_nxt = x_prev + ys;
          y_nxt = y_prev - xs;
          z_nxt = z_prev + $signed(cordic_angle(i));
        end
      end
    end else begin : g_hold
      assign x_nxt = x_prev;
      assign y_nxt = y_prev;
      assign z_nxt = z_prev;
    end

    always_ff @(posedge clk) begin
      if (en) begin
        x_r[i] <= x_nxt;
        y_r[i] <= y_nxt;
        z_r[i] <= z_nxt;
      end
    end
  end

  assign z_out = z_r[BR_LAT-1];

endmodule

@@ rtl/core/slto_trans.sv @@
// Pipelined Breit-Wigner transmission: 4*gl*gr / (4x^2 + s^2) in Q1.28.
module slto_trans #(
  parameter int X_W = 42
) (
  input  logic                      clk,
  input  logic                      en,
  input  logic signed [X_W-1:0]     x_in,
  input  logic [31:0]               s_in,
  input  logic [63:0]               n_in,
  output logic [slto_pkg::TR_STEPS-1:0] t_out
);
  import slto_pkg::*;

  localparam int HX    = (X_W + 1) / 2;
  localparam int XH_W  = X_W - HX;
  localparam int DEN_W = 2 * X_W + 3;
  localparam int R_W   = DEN_W + 1;

  // magnitude
  logic [X_W-1:0]  mag_r;
  logic [31:0]     s0_r;
  logic [63:0]     n0_r;
  // partial products
  logic [2*XH_W-1:0]   hh_r;
  logic [XH_W+HX-1:0]  hl_r;
  logic [2*HX-1:0]     ll_r;
  logic [63:0]         ss_r;
  logic [63:0]         n1_r;
  // denominator
  logic [DEN_W-1:0]    den_r;
  logic [63:0]         n2_r;

  logic [XH_W-1:0] xh;
  logic [HX-1:0]   xl;
  logic [DEN_W-1:0] sq, den_nxt;

  assign xh = mag_r[X_W-1:HX];
  assign xl = mag_r[HX-1:0];
  assign sq = (DEN_W'(hh_r) << (2 * HX)) + (DEN_W'(hl_r) << (HX + 1)) + DEN_W'(ll_r);
  assign den_nxt = (sq << 2) + DEN_W'(ss_r);

  always_ff @(posedge clk) begin
    if (en) begin
      mag_r <= x_in[X_W-1] ? X_W'(-x_in) : X_W'(x_in);
      s0_r  <= s_in;
      n0_r  <= n_in;
      hh_r  <= (2*XH_W)'(xh) * (2*XH_W)'(xh);
      hl_r  <= (XH_W+HX)'(xh) * (XH_W+HX)'(xl);
      ll_r  <= (2*HX)'(xl) * (2*HX)'(xl);
      ss_r  <= 64'(s0_r) * 64'(s0_r);
      n1_r  <= n0_r;
      den_r <= den_nxt;
      n2_r  <= n1_r;
    end
  end

  logic [R_W-1:0]      rem_r [TR_STEPS];
  logic [TR_STEPS-1:0] q_r   [TR_STEPS];
  logic [DEN_W-1:0]    dd_r  [TR_STEPS];

  for (genvar j = 0; j < TR_STEPS; j++) begin : g_div
    logic [R_W-1:0]      r_in, rem_nxt;
    logic [TR_STEPS-1:0] q_in;
    logic [DEN_W-1:0]    d_in;
    logic                ge;

    if (j == 0) begin : g_first
      assign r_in = R_W'(n2_r);
      assign q_in = '0;
      assign d_in = den_r;
    end else begin : g_next
      assign r_in = rem_r[j-1] << 1;
      assign q_in = q_r[j-1] << 1;
      assign d_in = dd_r[j-1];
    end

    assign ge      = r_in >= R_W'(d_in);
    assign rem_nxt = ge ? r_in - R_W'(d_in) : r_in;

    always_ff @(posedge clk) begin
      if (en) begin
        rem_r[j] <= rem_nxt;
        q_r[j]   <= q_in | TR_STEPS'(ge);
        dd_r[j]  <= d_in;
      end
    end
  end

  assign t_out = q_r[TR_STEPS-1];

endmodule

@@ rtl/core/single_level_transport_observables.sv @@
// Top level: single-level junction current and conductances, fully pipelined.
//
//  channel | direction | tdata (low bit up)                          | tuser
//  in_     | slave     | fermi, bias, level, gl(31), gr(31), asym    | -
//  out_    | master    | current, static, zero-bias, differential    | division_fault
//
// One beat per cycle in and out while the output is not stalled.
// The latency is set by the 32-stage branch (CORDIC pair, coupling divider,
// transmission dividers) and the 32-step static conductance divider.
// Reset clears only the valid bits; data registers are not reset.
// A stalled output freezes every stage; in_tready falls in the same cycle.
module single_level_transport_observables #(
  parameter int ENERGY_FRAC_BITS = 24,
  parameter int CORDIC_STAGES    = 24
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_tvalid,
  output logic         in_tready,
  // fermi_energy[31:0], bias_voltage[63:32], level_energy[95:64],
  // left_coupling[126:96], right_coupling[157:127], asymmetry[189:158], zero pad
  input  logic [191:0] in_tdata,
  output logic         out_tvalid,
  input  logic         out_tready,
  // current_units[31:0], static_conductance[63:32],
  // zero_bias_conductance[95:64], differential_conductance[127:96]
  output logic [127:0] out_tdata,
  // division_fault[0]
  output logic         out_tuser
);
  import slto_pkg::*;

  localparam int U_W        = 66 - ENERGY_FRAC_BITS;
  localparam int PIPE_DEPTH = 4 + BR_LAT + 3 + SD_STEPS + 1;
  localparam logic signed [32:0] HALF = 33'(1) << (ENERGY_FRAC_BITS - 1);

  logic                  adv;
  logic [PIPE_DEPTH-1:0] vld_r;

  assign adv        = !vld_r[PIPE_DEPTH-1] || out_tready;
  assign in_tready  = adv;
  assign out_tvalid = vld_r[PIPE_DEPTH-1];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (adv) begin
      vld_r <= {vld_r[PIPE_DEPTH-2:0], in_tvalid};
    end
  end

  // input beat
  logic signed [31:0] i_ef_r, i_v_r, i_eps_r, i_a_r;
  logic [30:0]        i_gl_r, i_gr_r;

  always_ff @(posedge clk) begin
    if (adv) begin
      i_ef_r  <= in_tdata[31:0];
      i_v_r   <= in_tdata[63:32];
      i_eps_r <= in_tdata[95:64];
      i_gl_r  <= in_tdata[126:96];
      i_gr_r  <= in_tdata[157:127];
      i_a_r   <= in_tdata[189:158];
    end
  end

  // stage A: sums and weights
  br_side_t           a_side_r;
  logic [31:0]        a_s_r;
  logic signed [32:0] a_d_r;
  logic [30:0]        a_gl_r, a_gr_r;

  always_ff @(posedge clk) begin
    if (adv) begin
      a_side_r.v  <= i_v_r;
      a_side_r.wl <= HALF - 33'(i_a_r);
      a_side_r.wr <= HALF + 33'(i_a_r);
      a_side_r.fs <= (i_gl_r == '0) && (i_gr_r == '0);
      a_side_r.fv <= (i_v_r == '0);
      a_s_r       <= 32'(i_gl_r) + 32'(i_gr_r);
      a_d_r       <= 33'(i_ef_r) - 33'(i_eps_r);
      a_gl_r      <= i_gl_r;
      a_gr_r      <= i_gr_r;
    end
  end

  // stage B: bias products and the coupling product
  br_side_t           b_side_r;
  logic signed [64:0] b_pl_r, b_pr_r;
  logic [61:0]        b_glgr_r;
  logic signed [32:0] b_d_r;
  logic [31:0]        b_s_r;

  always_ff @(posedge clk) begin
    if (adv) begin
      b_side_r <= a_side_r;
      b_pl_r   <= 65'(a_side_r.wl) * 65'(a_side_r.v);
      b_pr_r   <= 65'(a_side_r.wr) * 65'(a_side_r.v);
      b_glgr_r <= 62'(a_gl_r) * 62'(a_gr_r);
      b_d_r    <= a_d_r;
      b_s_r    <= a_s_r;
    end
  end

  // stage C: shifted level offsets and scaled coupling numerators
  br_side_t             c_side_r;
  logic signed [U_W-1:0] c_u_r, c_w_r;
  logic signed [32:0]   c_d_r;
  logic [31:0]          c_s_r;
  logic [62:0]          c_nh_r;
  logic [63:0]          c_nt_r;
  logic signed [64:0]   pl_sh, pr_sh;

  assign pl_sh = b_pl_r >>> ENERGY_FRAC_BITS;
  assign pr_sh = b_pr_r >>> ENERGY_FRAC_BITS;

  always_ff @(posedge clk) begin
    if (adv) begin
      c_side_r <= b_side_r;
      c_u_r    <= U_W'(65'(b_d_r) + pl_sh);
      c_w_r    <= U_W'(65'(b_d_r) - pr_sh);
      c_d_r    <= b_d_r;
      c_s_r    <= b_s_r;
      c_nh_r   <= {b_glgr_r, 1'b0};
      c_nt_r   <= {b_glgr_r, 2'b00};
    end
  end

  // branch: arctangents
  logic signed [31:0] zu, zw;

  slto_cordic #(.Y_W(U_W + 1), .STAGES(CORDIC_STAGES)) u_cordic_u (
    .clk   (clk),
    .en    (adv),
    .y_in  ({c_u_r, 1'b0}),
    .x_in  (c_s_r),
    .z_out (zu)
  );

  slto_cordic #(.Y_W(U_W + 1), .STAGES(CORDIC_STAGES)) u_cordic_w (
    .clk   (clk),
    .en    (adv),
    .y_in  ({c_w_r, 1'b0}),
    .x_in  (c_s_r),
    .z_out (zw)
  );

  // branch: transmissions
  logic [TR_STEPS-1:0] td, tu, tw;

  slto_trans #(.X_W(U_W)) u_trans_d (
    .clk   (clk),
    .en    (adv),
    .x_in  (U_W'(c_d_r)),
    .s_in  (c_s_r),
    .n_in  (c_nt_r),
    .t_out (td)
  );

  slto_trans #(.X_W(U_W)) u_trans_u (
    .clk   (clk),
    .en    (adv),
    .x_in  (c_u_r),
    .s_in  (c_s_r),
    .n_in  (c_nt_r),
    .t_out (tu)
  );

  slto_trans #(.X_W(U_W)) u_trans_w (
    .clk   (clk),
    .en    (adv),
    .x_in  (c_w_r),
    .s_in  (c_s_r),
    .n_in  (c_nt_r),
    .t_out (tw)
  );

  // branch: h = 2 gl gr / s, one quotient bit per stage
  logic [63:0]       hrem_r [BR_LAT];
  logic [BR_LAT-1:0] hq_r   [BR_LAT];
  logic [31:0]       hs_r   [BR_LAT];

  for (genvar k = 0; k < BR_LAT; k++) begin : g_hdiv
    logic [63:0]       rem_in, dsh, rem_nxt;
    logic [BR_LAT-1:0] q_in, q_nxt;
    logic [31:0]       s_in;
    logic              ge;

    if (k == 0) begin : g_first
      assign rem_in = 64'(c_nh_r);
      assign q_in   = '0;
      assign s_in   = c_s_r;
    end else begin : g_next
      assign rem_in = hrem_r[k-1];
      assign q_in   = hq_r[k-1];
      assign s_in   = hs_r[k-1];
    end

    assign dsh     = 64'(s_in) << (BR_LAT - 1 - k);
    assign ge      = rem_in >= dsh;
    assign rem_nxt = ge ? rem_in - dsh : rem_in;

    always_comb begin
      q_nxt = q_in;
      q_nxt[BR_LAT-1-k] = ge;
    end

    always_ff @(posedge clk) begin
      if (adv) begin
        hrem_r[k] <= rem_nxt;
        hq_r[k]   <= q_nxt;
        hs_r[k]   <= s_in;
      end
    end
  end

  // side band alongside the branch
  br_side_t br_r [BR_LAT];

  for (genvar k = 0; k < BR_LAT; k++) begin : g_brdly
    if (k == 0) begin : g_first
      always_ff @(posedge clk) begin
        if (adv) begin
          br_r[k] <= c_side_r;
        end
      end
    end else begin : g_next
      always_ff @(posedge clk) begin
        if (adv) begin
          br_r[k] <= br_r[k-1];
        end
      end
    end
  end

  // stage J: angle difference
  br_side_t            j_side_r;
  logic signed [32:0]  j_zd_r;
  logic [31:0]         j_h_r;
  logic [TR_STEPS-1:0] j_td_r, j_tu_r, j_tw_r;

  always_ff @(posedge clk) begin
    if (adv) begin
      j_side_r <= br_r[BR_LAT-1];
      j_zd_r   <= 33'(zu) - 33'(zw);
      j_h_r    <= hq_r[BR_LAT-1];
      j_td_r   <= td;
      j_tu_r   <= tu;
      j_tw_r   <= tw;
    end
  end

  // stage K: current and weighted transmission products
  logic signed [65:0]  k_cp_r;
  logic signed [62:0]  k_dl_r, k_dr_r;
  logic [TR_STEPS-1:0] k_td_r;
  logic signed [31:0]  k_v_r;
  logic                k_fs_r, k_fv_r;

  always_ff @(posedge clk) begin
    if (adv) begin
      k_cp_r <= 66'($signed({1'b0, j_h_r})) * 66'(j_zd_r);
      k_dl_r <= 63'(j_side_r.wl) * 63'($signed({1'b0, j_tu_r}));
      k_dr_r <= 63'(j_side_r.wr) * 63'($signed({1'b0, j_tw_r}));
      k_td_r <= j_td_r;
      k_v_r  <= j_side_r.v;
      k_fs_r <= j_side_r.fs;
      k_fv_r <= j_side_r.fv;
    end
  end

  // stage L: scale, saturate, set up the static divider
  logic signed [35:0] l_cur;
  logic signed [63:0] dsum, dsum_sh;
  sd_side_t           l_side_nxt, l_side_r;
  logic [63:0]        l_num_r;
  logic [31:0]        l_vmag_r;

  assign l_cur   = $signed(k_cp_r[65:30]);
  assign dsum    = 64'(k_dl_r) + 64'(k_dr_r);
  assign dsum_sh = dsum >>> ENERGY_FRAC_BITS;

  always_comb begin
    l_side_nxt.cur  = sat_to32(64'(l_cur));
    l_side_nxt.diff = sat_to32(dsum_sh);
    l_side_nxt.td   = k_td_r;
    l_side_nxt.neg  = l_cur[35] ^ k_v_r[31];
    l_side_nxt.fs   = k_fs_r;
    l_side_nxt.fv   = k_fv_r;
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      l_side_r <= l_side_nxt;
      l_num_r  <= {(l_cur[35] ? 36'(-l_cur) : 36'(l_cur)), 28'b0};
      l_vmag_r <= k_v_r[31] ? 32'(-k_v_r) : 32'(k_v_r);
    end
  end

  // static conductance: |cur| * 2^28 / |v|, one quotient bit per stage
  logic [63:0]         srem_r [SD_STEPS];
  logic [SD_STEPS-1:0] sq_r   [SD_STEPS];
  logic [31:0]         svm_r  [SD_STEPS];
  logic                sovf_r [SD_STEPS];
  sd_side_t            sside_r[SD_STEPS];

  for (genvar k = 0; k < SD_STEPS; k++) begin : g_sdiv
    logic [63:0]         rem_in, dsh, rem_nxt;
    logic [SD_STEPS-1:0] q_in, q_nxt;
    logic [31:0]         vm_in;
    logic                ovf_in, ge;
    sd_side_t            side_in;

    if (k == 0) begin : g_first
      assign rem_in  = l_num_r;
      assign q_in    = '0;
      assign vm_in   = l_vmag_r;
      // quotient would not fit 32 bits
      assign ovf_in  = {1'b0, l_num_r} >= {1'b0, l_vmag_r, 32'b0};
      assign side_in = l_side_r;
    end else begin : g_next
      assign rem_in  = srem_r[k-1];
      assign q_in    = sq_r[k-1];
      assign vm_in   = svm_r[k-1];
      assign ovf_in  = sovf_r[k-1];
      assign side_in = sside_r[k-1];
    end

    assign dsh     = 64'(vm_in) << (SD_STEPS - 1 - k);
    assign ge      = rem_in >= dsh;
    assign rem_nxt = ge ? rem_in - dsh : rem_in;

    always_comb begin
      q_nxt = q_in;
      q_nxt[SD_STEPS-1-k] = ge;
    end

    always_ff @(posedge clk) begin
      if (adv) begin
        srem_r[k]  <= rem_nxt;
        sq_r[k]    <= q_nxt;
        svm_r[k]   <= vm_in;
        sovf_r[k]  <= ovf_in;
        sside_r[k] <= side_in;
      end
    end
  end

  // output register
  sd_side_t    o_side;
  logic [31:0] o_q, stat_val;
  logic [31:0] o_cur_nxt, o_stat_nxt, o_zbc_nxt, o_diff_nxt;
  logic        o_fault_nxt;
  logic [31:0] o_cur_r, o_stat_r, o_zbc_r, o_diff_r;
  logic        o_fault_r;

  assign o_side = sside_r[SD_STEPS-1];
  assign o_q    = sq_r[SD_STEPS-1];

  always_comb begin
    if (sovf_r[SD_STEPS-1]) begin
      stat_val = o_side.neg ? SAT_MIN : SAT_MAX;
    end else if (o_side.neg) begin
      stat_val = (o_q > SAT_MIN) ? SAT_MIN : 32'(32'd0 - o_q);
    end else begin
      stat_val = o_q[31] ? SAT_MAX : o_q;
    end
  end

  always_comb begin
    if (o_side.fs) begin
      o_cur_nxt   = '0;
      o_stat_nxt  = '0;
      o_zbc_nxt   = '0;
      o_diff_nxt  = '0;
      o_fault_nxt = 1'b1;
    end else begin
      o_cur_nxt   = o_side.cur;
      o_stat_nxt  = o_side.fv ? 32'd0 : stat_val;
      o_zbc_nxt   = 32'(o_side.td);
      o_diff_nxt  = o_side.diff;
      o_fault_nxt = o_side.fv;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      o_cur_r   <= o_cur_nxt;
      o_stat_r  <= o_stat_nxt;
      o_zbc_r   <= o_zbc_nxt;
      o_diff_r  <= o_diff_nxt;
      o_fault_r <= o_fault_nxt;
    end
  end

  assign out_tdata = {o_diff_r, o_zbc_r, o_stat_r, o_cur_r};
  assign out_tuser = o_fault_r;

`ifndef SYNTHESIS
  a_fault_static_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser |-> out_tdata[63:32] == '0)
    else $error("static conductance nonzero on a faulted beat");

  a_zbc_bound: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> out_tdata[95:64] <= TR_ONE)
    else $error("zero-bias transmission above one");

  a_stall_freeze: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> $stable(vld_r))
    else $error("pipeline moved during an output stall");
`endif

endmodule
